[rtl/mip_level_reduce_2x2_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef MIP_LEVEL_REDUCE_2X2_MACROS_SVH
`define MIP_LEVEL_REDUCE_2X2_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define MLR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/mlr_pkg.sv]
`default_nettype none

package mlr_pkg;

  // Port and register widths fixed by the interface
  localparam int FIELD_W    = 16;
  localparam int NUM_CHAN   = 4;
  localparam int TDATA_W    = FIELD_W * NUM_CHAN;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_REG_W  = 13;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 3;

  // Register reset values and channel count bounds
  localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 13'd2;
  localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 13'd2;
  localparam logic [MODE_W-1:0]    MODE_RESET   = 2'd0;
  localparam logic [COUNT_W-1:0]   COUNT_RESET  = 3'd4;
  localparam logic [COUNT_W-1:0]   COUNT_MAX    = 3'd4;
  localparam logic [COUNT_W-1:0]   COUNT_MIN    = 3'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_REDUCE_MODE = 2'd2,
    REG_CHAN_COUNT = 2'd3
  } cfg_reg_e;

  // Reduce modes; the unused code acts as average
  typedef enum logic [MODE_W-1:0] {
    MODE_AVG = 2'd0,
    MODE_MIN = 2'd1,
    MODE_MAX = 2'd2
  } reduce_mode_e;

  // Role of the pixel at the current position
  typedef struct packed {
    logic is_store;
    logic is_hold;
    logic is_reduce;
    logic level_end;
  } pos_info_t;

endpackage

`default_nettype wire

[rtl/mlr_pos.sv]
`default_nettype none

module mlr_pos #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [mlr_pkg::DIM_REG_W-1:0]   src_width_i,
  input  wire logic [mlr_pkg::DIM_REG_W-1:0]   src_height_i,
  input  wire logic                            restart_i,
  input  wire logic                            advance_i,
  output mlr_pkg::pos_info_t                   info_o,
  output logic [$clog2(MAX_DIM)-1:0]           row_o
);

  localparam int DW  = $clog2(MAX_DIM);
  localparam int CDW = $clog2(MAX_DIM + 1);
  localparam int EW  = (CDW > mlr_pkg::DIM_REG_W) ? CDW : mlr_pkg::DIM_REG_W;

  logic [DW-1:0]  col_q, col_d, row_q, row_d;
  logic [DW-1:0]  col_eff, row_eff;
  logic [EW-1:0]  w_ext, h_ext, w_lim, h_lim;
  logic [CDW-1:0] w_cl, h_cl, w_even, h_even, c_ext, r_ext;
  logic           out_of_range, last_row, last_col;

  // Clamp the geometry to 2..MAX_DIM
  always_comb begin
    w_ext = EW'(src_width_i);
    h_ext = EW'(src_height_i);
    w_lim = (w_ext < EW'(2)) ? EW'(2) : ((w_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : w_ext);
    h_lim = (h_ext < EW'(2)) ? EW'(2) : ((h_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : h_ext);
    w_cl  = CDW'(w_lim);
    h_cl  = CDW'(h_lim);
    w_even = {w_cl[CDW-1:1], 1'b0};
    h_even = {h_cl[CDW-1:1], 1'b0};
  end

  // Classify the current position
  always_comb begin
    out_of_range = (CDW'(col_q) >= w_cl) || (CDW'(row_q) >= h_cl);
    col_eff  = out_of_range ? '0 : col_q;
    row_eff  = out_of_range ? '0 : row_q;
    c_ext    = CDW'(col_eff);
    r_ext    = CDW'(row_eff);
    last_row = (r_ext == h_cl - CDW'(1));
    last_col = (c_ext == w_cl - CDW'(1));

    info_o.is_store  = !col_eff[0];
    info_o.is_hold   = col_eff[0] && !row_eff[0];
    info_o.is_reduce = col_eff[0] && row_eff[0];
    info_o.level_end = (c_ext == w_even - CDW'(1)) && (r_ext == h_even - CDW'(1));
    row_o = row_eff;
  end

  // Advance row first, then column, wrapping after the last row of the last column
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (advance_i) begin
      if (last_row) begin
        row_d = '0;
        col_d = last_col ? '0 : col_eff + DW'(1);
      end else begin
        row_d = row_eff + DW'(1);
        col_d = col_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

[rtl/mlr_lane.sv]
`default_nettype none

module mlr_lane #(
  parameter int CHAN_BITS = 16
) (
  input  wire logic [mlr_pkg::MODE_W-1:0] mode_i,
  input  wire logic                       enable_i,
  input  wire logic [CHAN_BITS-1:0]       up_left_i,
  input  wire logic [CHAN_BITS-1:0]       up_i,
  input  wire logic [CHAN_BITS-1:0]       left_i,
  input  wire logic [CHAN_BITS-1:0]       cur_i,
  output logic [CHAN_BITS-1:0]            result_o
);

  logic [CHAN_BITS+1:0] sum;
  logic [CHAN_BITS-1:0] min_a, min_b, max_a, max_b, min_all, max_all;

  // Sum, min tree and max tree over the 2x2 block
  always_comb begin
    sum = (CHAN_BITS+2)'(up_left_i) + (CHAN_BITS+2)'(up_i)
        + (CHAN_BITS+2)'(left_i) + (CHAN_BITS+2)'(cur_i);
    min_a   = (up_left_i < up_i) ? up_left_i : up_i;
    min_b   = (left_i < cur_i) ? left_i : cur_i;
    min_all = (min_a < min_b) ? min_a : min_b;
    max_a   = (up_left_i > up_i) ? up_left_i : up_i;
    max_b   = (left_i > cur_i) ? left_i : cur_i;
    max_all = (max_a > max_b) ? max_a : max_b;
  end

  // Select by mode; an inactive channel gives zero
  always_comb begin
    unique case (mode_i)
      mlr_pkg::MODE_MIN: result_o = min_all;
      mlr_pkg::MODE_MAX: result_o = max_all;
      default:           result_o = sum[CHAN_BITS+1:2];
    endcase
    if (!enable_i) begin
      result_o = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/mlr_merge.sv]
`default_nettype none

module mlr_merge #(
  parameter int CHAN_BITS = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         load_i,
  input  wire logic [mlr_pkg::NUM_CHAN-1:0][CHAN_BITS-1:0]  lane_res_i,
  input  wire logic                                         level_end_i,
  output logic                                              space_o,
  output logic                                              m_axis_tvalid_o,
  input  wire logic                                         m_axis_tready_i,
  // red_a, red_b, red_c, red_d, 16 bits each from the lowest bit up
  output logic [mlr_pkg::TDATA_W-1:0]                       m_axis_tdata_o,
  // level_end
  output logic                                              m_axis_tlast_o
);

  logic                          valid_q, valid_d;
  logic [mlr_pkg::TDATA_W-1:0]   data_q, data_d;
  logic                          last_q, last_d;

  // Pack the lane results into the output word
  always_comb begin
    data_d = data_q;
    last_d = last_q;
    if (load_i) begin
      for (int k = 0; k < mlr_pkg::NUM_CHAN; k++) begin
        data_d[k*mlr_pkg::FIELD_W +: mlr_pkg::FIELD_W] = mlr_pkg::FIELD_W'(lane_res_i[k]);
      end
      last_d = level_end_i;
    end
  end

  // Hold the result until the downstream side takes it
  always_comb begin
    space_o = !valid_q || m_axis_tready_i;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire

[rtl/mip_level_reduce_2x2.sv]
// An odd-row, odd-column input passes the reduce stage and output registers to m_axis_tvalid_o.
// Throughput: one pixel per cycle unless stalled, set by the column store's single write port
// and two read ports; a pixel either writes the store once, reads it twice or leaves it alone.
// Reset: geometry 2x2, average mode, four channels, position at column 0 row 0, pipeline
// empty; the column store is not cleared and needs no clearing pass.
`default_nettype none
`include "mip_level_reduce_2x2_macros.svh"

module mip_level_reduce_2x2 #(
  parameter int MAX_DIM   = 4096,
  parameter int CHAN_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [mlr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mlr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // chan_a, chan_b, chan_c, chan_d, 16 bits each from the lowest bit up
  input  wire logic [mlr_pkg::TDATA_W-1:0]        s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // red_a, red_b, red_c, red_d, 16 bits each from the lowest bit up
  output logic [mlr_pkg::TDATA_W-1:0]             m_axis_tdata_o,
  // level_end
  output logic                                    m_axis_tlast_o
);

  localparam int AW = $clog2(MAX_DIM);
  localparam int PW = CHAN_BITS * mlr_pkg::NUM_CHAN;

  // Configuration registers
  logic [mlr_pkg::DIM_REG_W-1:0] width_q, height_q;
  logic [mlr_pkg::MODE_W-1:0]    mode_q;
  logic [mlr_pkg::COUNT_W-1:0]   count_q, nch;
  logic                          restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mlr_pkg::WIDTH_RESET;
      height_q <= mlr_pkg::HEIGHT_RESET;
      mode_q   <= mlr_pkg::MODE_RESET;
      count_q  <= mlr_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlr_pkg::REG_SRC_WIDTH:   width_q  <= cfg_data_i;
        mlr_pkg::REG_SRC_HEIGHT:  height_q <= cfg_data_i;
        mlr_pkg::REG_REDUCE_MODE: mode_q   <= cfg_data_i[mlr_pkg::MODE_W-1:0];
        mlr_pkg::REG_CHAN_COUNT:  count_q  <= cfg_data_i[mlr_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_i == mlr_pkg::REG_SRC_WIDTH) ||
                                (cfg_idx_i == mlr_pkg::REG_SRC_HEIGHT));

  // Clamp the channel count to 1..4
  always_comb begin
    if (count_q < mlr_pkg::COUNT_MIN) begin
      nch = mlr_pkg::COUNT_MIN;
    end else if (count_q > mlr_pkg::COUNT_MAX) begin
      nch = mlr_pkg::COUNT_MAX;
    end else begin
      nch = count_q;
    end
  end

  // Position tracking
  mlr_pkg::pos_info_t info;
  logic [AW-1:0]      row;
  logic               accept, s1_adv, merge_space;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  mlr_pos #(
    .MAX_DIM (MAX_DIM)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_width_i  (width_q),
    .src_height_i (height_q),
    .restart_i    (restart),
    .advance_i    (accept),
    .info_o       (info),
    .row_o        (row)
  );

  // Take the low CHAN_BITS of each channel field
  logic [PW-1:0] pix;
  always_comb begin
    for (int k = 0; k < mlr_pkg::NUM_CHAN; k++) begin
      pix[k*CHAN_BITS +: CHAN_BITS] = s_axis_tdata_i[k*mlr_pkg::FIELD_W +: CHAN_BITS];
    end
  end

  // Column store: write on even columns, read two rows on completing blocks
  logic [PW-1:0] col_store_q [MAX_DIM];
  logic [PW-1:0] up_left_q, left_q;
  logic [AW-1:0] wr_addr, rd_up_addr;

  assign wr_addr    = row & AW'(MAX_DIM - 1);
  assign rd_up_addr = row - AW'(1);

  always_ff @(posedge clk_i) begin
    if (accept && info.is_store) begin
      col_store_q[wr_addr] <= pix;
    end
    if (accept && info.is_reduce) begin
      up_left_q <= col_store_q[rd_up_addr];
      left_q    <= col_store_q[row];
    end
  end

  // Held pixel of the odd column on the even row
  logic [PW-1:0] held_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (accept && info.is_hold) begin
      held_q <= pix;
    end
  end

  // Reduce stage registers
  logic          s1_valid_q, s1_valid_d;
  logic [PW-1:0] s1_pix_q;
  logic          s1_last_q;

  assign s1_adv          = s1_valid_q && merge_space;
  assign s_axis_tready_o = !s1_valid_q || merge_space;

  always_comb begin
    if (accept && info.is_reduce) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && info.is_reduce) begin
      s1_pix_q  <= pix;
      s1_last_q <= info.level_end;
    end
  end

  // One lane per channel
  logic [mlr_pkg::NUM_CHAN-1:0][CHAN_BITS-1:0] lane_res;

  for (genvar k = 0; k < mlr_pkg::NUM_CHAN; k++) begin : g_lane
    mlr_lane #(
      .CHAN_BITS (CHAN_BITS)
    ) u_lane (
      .mode_i    (mode_q),
      .enable_i  (nch > mlr_pkg::COUNT_W'(k)),
      .up_left_i (up_left_q[k*CHAN_BITS +: CHAN_BITS]),
      .up_i      (held_q[k*CHAN_BITS +: CHAN_BITS]),
      .left_i    (left_q[k*CHAN_BITS +: CHAN_BITS]),
      .cur_i     (s1_pix_q[k*CHAN_BITS +: CHAN_BITS]),
      .result_o  (lane_res[k])
    );
  end

  // Merge lane results into the output register
  mlr_merge #(
    .CHAN_BITS (CHAN_BITS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (s1_adv),
    .lane_res_i      (lane_res),
    .level_end_i     (s1_last_q),
    .space_o         (merge_space),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Assertions
  `MLR_ASSERT(a_role_onehot, !accept || $onehot({info.is_store, info.is_hold, info.is_reduce}),
    "pixel role is not unique")
  `MLR_ASSERT_NEXT(a_reduce_enters, accept && info.is_reduce, s1_valid_q,
    "completed block did not enter the reduce stage")
  `MLR_ASSERT_NEXT(a_s1_holds, s1_valid_q && !merge_space, s1_valid_q,
    "stalled reduce stage lost its block")
  `MLR_ASSERT(a_no_accept_full, !(s1_valid_q && m_axis_tvalid_o && !m_axis_tready_i) ||
    !s_axis_tready_o, "input accepted while both stages are full")

endmodule

`default_nettype wire

[verif/tb_mip_level_reduce_2x2.sv]
`default_nettype none

module tb_mip_level_reduce_2x2;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM          = 4096;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 6;
  localparam int RANDOM_ITEMS     = 320;
  localparam int CALM_ITEMS       = 100;

  typedef struct packed {
    logic [mlr_pkg::NUM_CHAN-1:0][mlr_pkg::FIELD_W-1:0] red;
    logic                                               level_end;
  } reduced_px_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [mlr_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [mlr_pkg::CFG_DATA_W-1:0]  cfg_data_i;
  logic                            s_axis_tvalid_i;
  logic                            s_axis_tready_o;
  // chan_a, chan_b, chan_c, chan_d, 16 bits each from the lowest bit up
  logic [mlr_pkg::TDATA_W-1:0]     s_axis_tdata_i;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i;
  // red_a, red_b, red_c, red_d, 16 bits each from the lowest bit up
  logic [mlr_pkg::TDATA_W-1:0]     m_axis_tdata_o;
  // level_end
  logic                            m_axis_tlast_o;

  // Predictor copy of the block state and registers
  logic [mlr_pkg::TDATA_W-1:0]     column_buf [MAX_DIM];
  logic [mlr_pkg::TDATA_W-1:0]     held_px;
  int unsigned                     col_pos;
  int unsigned                     row_pos;
  logic [mlr_pkg::DIM_REG_W-1:0]   geo_width;
  logic [mlr_pkg::DIM_REG_W-1:0]   geo_height;
  logic [mlr_pkg::MODE_W-1:0]      reduce_sel;
  logic [mlr_pkg::COUNT_W-1:0]     chan_sel;

  reduced_px_t            pending_reduced [$];
  int                     err_count = 0;
  int unsigned            quiet_cycles = 0;
  bit                     src_gaps_en = 1'b0;
  bit                     sink_stalls_en = 1'b0;
  bit                     sink_hold_req = 1'b0;

  mip_level_reduce_2x2 #(
    .MAX_DIM  (MAX_DIM),
    .CHAN_BITS(mlr_pkg::FIELD_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_dim(logic [mlr_pkg::DIM_REG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Reduce one channel of the 2x2 block under the current mode
  function automatic logic [mlr_pkg::FIELD_W-1:0] combine_block(
    logic [mlr_pkg::FIELD_W-1:0] a, b, c, d);
    logic [mlr_pkg::FIELD_W+1:0] sum;
    logic [mlr_pkg::FIELD_W-1:0] pick;
    case (reduce_sel)
      mlr_pkg::MODE_MIN: begin
        pick = a;
        if (b < pick) pick = b;
        if (c < pick) pick = c;
        if (d < pick) pick = d;
        return pick;
      end
      mlr_pkg::MODE_MAX: begin
        pick = a;
        if (b > pick) pick = b;
        if (c > pick) pick = c;
        if (d > pick) pick = d;
        return pick;
      end
      default: begin
        // the unused mode code falls back to average
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return sum[mlr_pkg::FIELD_W+1:2];
      end
    endcase
  endfunction

  function automatic void reset_prediction();
    held_px    = '0;
    col_pos    = 0;
    row_pos    = 0;
    geo_width  = mlr_pkg::WIDTH_RESET;
    geo_height = mlr_pkg::HEIGHT_RESET;
    reduce_sel = mlr_pkg::MODE_RESET;
    chan_sel   = mlr_pkg::COUNT_RESET;
  endfunction

  function automatic void apply_reg(mlr_pkg::cfg_reg_e idx,
                                    logic [mlr_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      mlr_pkg::REG_SRC_WIDTH: begin
        geo_width = v;
        col_pos   = 0;
        row_pos   = 0;
      end
      mlr_pkg::REG_SRC_HEIGHT: begin
        geo_height = v;
        col_pos    = 0;
        row_pos    = 0;
      end
      mlr_pkg::REG_REDUCE_MODE: reduce_sel = v[mlr_pkg::MODE_W-1:0];
      mlr_pkg::REG_CHAN_COUNT:  chan_sel   = v[mlr_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the position by one source pixel and queue the reduced pixel it completes
  function automatic void predict_reduction(logic [mlr_pkg::TDATA_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned nch;
    int          k;
    logic [mlr_pkg::TDATA_W-1:0] up_left;
    logic [mlr_pkg::TDATA_W-1:0] left;
    reduced_px_t res;
    w   = clamp_dim(geo_width);
    h   = clamp_dim(geo_height);
    nch = chan_sel;
    if (nch < mlr_pkg::COUNT_MIN) nch = mlr_pkg::COUNT_MIN;
    if (nch > mlr_pkg::COUNT_MAX) nch = mlr_pkg::COUNT_MAX;
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos % 2 == 0) begin
      column_buf[row_pos] = px;
    end else if (row_pos % 2 == 0) begin
      held_px = px;
    end else begin
      up_left = column_buf[row_pos - 1];
      left    = column_buf[row_pos];
      for (k = 0; k < mlr_pkg::NUM_CHAN; k++) begin
        if (k < nch)
          res.red[k] = combine_block(up_left[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W],
                                     held_px[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W],
                                     left[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W],
                                     px[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W]);
        else
          res.red[k] = '0;
      end
      res.level_end = (col_pos == (w / 2) * 2 - 1) && (row_pos == (h / 2) * 2 - 1);
      pending_reduced.push_back(res);
    end
    row_pos++;
    if (row_pos >= h) begin
      row_pos = 0;
      col_pos++;
      if (col_pos >= w) col_pos = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Bias each channel toward its extremes
  function automatic logic [mlr_pkg::TDATA_W-1:0] rand_pixel();
    logic [mlr_pkg::TDATA_W-1:0] px;
    int k;
    for (k = 0; k < mlr_pkg::NUM_CHAN; k++) begin
      case ($urandom_range(0, 7))
        0:       px[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W] = '0;
        1:       px[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W] = '1;
        default: px[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W] = mlr_pkg::FIELD_W'($urandom);
      endcase
    end
    return px;
  endfunction

  task automatic set_reg(mlr_pkg::cfg_reg_e idx, logic [mlr_pkg::CFG_DATA_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    apply_reg(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one pixel, optionally after a gap, and predict once the transaction completes
  task automatic send_pixel(logic [mlr_pkg::TDATA_W-1:0] px);
    if (src_gaps_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_reduction(px);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // 2x2 block of three fixed pixels and one random one, touching both ends of every channel
  task automatic send_extreme_block();
    send_pixel({mlr_pkg::NUM_CHAN{16'h0000}});
    send_pixel({mlr_pkg::NUM_CHAN{16'hFFFF}});
    send_pixel({16'h7FFF, 16'hFFFE, 16'h8000, 16'h0001});
    send_pixel(rand_pixel());
  endtask

  // Stop offering, wait for every expected result, then let the pipeline settle
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_reduced.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Output ready: short random stalls, or one long hold-off when requested
  initial begin : sink_ready
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (sink_stalls_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Compare each output transaction with the oldest expected reduced pixel
  always @(posedge clk_i) begin : result_check
    reduced_px_t want;
    int k;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_reduced.size() == 0) begin
        $display("%0t: unexpected result data %h last %b", $time, m_axis_tdata_o,
                 m_axis_tlast_o);
        err_count++;
      end else begin
        want = pending_reduced.pop_front();
        for (k = 0; k < mlr_pkg::NUM_CHAN; k++) begin
          if (m_axis_tdata_o[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W] !== want.red[k]) begin
            $display("%0t: red channel %0d expected %h got %h", $time, k, want.red[k],
                     m_axis_tdata_o[mlr_pkg::FIELD_W*k +: mlr_pkg::FIELD_W]);
            err_count++;
          end
        end
        if (m_axis_tlast_o !== want.level_end) begin
          $display("%0t: level_end expected %b got %b", $time, want.level_end,
                   m_axis_tlast_o);
          err_count++;
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[mip_level_reduce_2x2] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry: one saturated block, then a second level after the wrap
  task automatic test_default_geometry();
    repeat (4) send_pixel({mlr_pkg::NUM_CHAN{16'hFFFF}});
    send_extreme_block();
    drain_results();
  endtask

  // Minimum, maximum and the spare mode code, with channel counts in and out of range
  task automatic test_modes_and_channels();
    set_reg(mlr_pkg::REG_REDUCE_MODE, mlr_pkg::CFG_DATA_W'(mlr_pkg::MODE_MIN));
    set_reg(mlr_pkg::REG_CHAN_COUNT, 13'd3);
    send_extreme_block();
    drain_results();
    set_reg(mlr_pkg::REG_REDUCE_MODE, mlr_pkg::CFG_DATA_W'(mlr_pkg::MODE_MAX));
    set_reg(mlr_pkg::REG_CHAN_COUNT, 13'd7);
    send_extreme_block();
    drain_results();
    set_reg(mlr_pkg::REG_REDUCE_MODE, 13'd3);
    set_reg(mlr_pkg::REG_CHAN_COUNT, 13'd0);
    send_extreme_block();
    drain_results();
  endtask

  // Odd last column and row are dropped; dimensions clamp at both ends
  task automatic test_odd_and_clamped_dims();
    set_reg(mlr_pkg::REG_SRC_WIDTH, 13'd3);
    set_reg(mlr_pkg::REG_SRC_HEIGHT, 13'd3);
    set_reg(mlr_pkg::REG_REDUCE_MODE, mlr_pkg::CFG_DATA_W'(mlr_pkg::MODE_AVG));
    set_reg(mlr_pkg::REG_CHAN_COUNT, 13'd2);
    send_random(9);
    drain_results();
    // width clamps to the maximum, height to two: only the first block of the level
    set_reg(mlr_pkg::REG_SRC_WIDTH, 13'd8191);
    set_reg(mlr_pkg::REG_SRC_HEIGHT, 13'd1);
    set_reg(mlr_pkg::REG_CHAN_COUNT, 13'd4);
    send_random(4);
    drain_results();
  endtask

  // Full level of two tall columns, well past the rows of the random levels
  task automatic test_tallest_level();
    set_reg(mlr_pkg::REG_SRC_WIDTH, 13'd2);
    set_reg(mlr_pkg::REG_SRC_HEIGHT, 13'd40);
    set_reg(mlr_pkg::REG_REDUCE_MODE, mlr_pkg::CFG_DATA_W'(mlr_pkg::MODE_MAX));
    send_random(80);
    drain_results();
  endtask

  // Hold the output off long enough that the block must stall its input
  task automatic test_output_backpressure();
    set_reg(mlr_pkg::REG_SRC_WIDTH, 13'd8);
    set_reg(mlr_pkg::REG_SRC_HEIGHT, 13'd8);
    set_reg(mlr_pkg::REG_REDUCE_MODE, mlr_pkg::CFG_DATA_W'(mlr_pkg::MODE_AVG));
    src_gaps_en    = 1'b0;
    sink_stalls_en = 1'b0;
    sink_hold_req  = 1'b1;
    send_random(64);
    drain_results();
    src_gaps_en    = 1'b1;
    sink_stalls_en = 1'b1;
  endtask

  // Random geometry and settings; mostly whole levels, some cut short
  task automatic test_random_levels();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
        src_gaps_en    = 1'b0;
        sink_stalls_en = 1'b0;
      end
      if ($urandom_range(0, 3) != 0) begin
        set_reg(mlr_pkg::REG_SRC_WIDTH, mlr_pkg::CFG_DATA_W'($urandom_range(0, 9)));
        set_reg(mlr_pkg::REG_SRC_HEIGHT, mlr_pkg::CFG_DATA_W'($urandom_range(0, 9)));
      end
      // upper data bits are don't-care for these two registers
      set_reg(mlr_pkg::REG_REDUCE_MODE, mlr_pkg::CFG_DATA_W'($urandom));
      set_reg(mlr_pkg::REG_CHAN_COUNT, mlr_pkg::CFG_DATA_W'($urandom));
      w = clamp_dim(geo_width);
      h = clamp_dim(geo_height);
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, w * h - 1);
      send_random(n);
      sent += n;
      drain_results();
    end
  endtask

  initial begin : main_seq
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = mlr_pkg::REG_SRC_WIDTH;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    reset_prediction();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_gaps_en    = 1'b1;
    sink_stalls_en = 1'b1;
    test_default_geometry();
    test_modes_and_channels();
    test_odd_and_clamped_dims();
    test_tallest_level();
    test_output_backpressure();
    test_random_levels();

    if (err_count == 0) begin
      $display("[mip_level_reduce_2x2] OK");
    end else begin
      $display("[mip_level_reduce_2x2] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
